FILE: rtl/rsm_pkg.sv
// Package: shared constants and types for the running set median block.
`default_nettype none

package rsm_pkg;

    // Store capacity and element width
    localparam int MAX_COUNT   = 256;
    localparam int VALUE_WIDTH = 32;

    // Derived widths
    localparam int ADDR_W = $clog2(MAX_COUNT);
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);

    // Fixed result field widths
    localparam int MEDIAN_W = 32;
    localparam int USED_W   = 9;

    // Offset-binary bias: flips the sign bit so an unsigned compare orders signed values
    localparam logic [VALUE_WIDTH-1:0] VAL_BIAS = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef logic [VALUE_WIDTH-1:0] word_t;

    // Results of the shared compare / average unit
    typedef struct packed {
        logic  gt;    // a > b, unsigned on biased words
        word_t mean;  // floor((a + b) / 2) without overflow
    } unit_res_t;

endpackage

`default_nettype wire

FILE: rtl/rsm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/rsm_unit.sv
// Shared arithmetic unit: ordering compare and floor average of two biased words.
`default_nettype none

module rsm_unit (
    input  wire logic              [rsm_pkg::VALUE_WIDTH-1:0] a,
    input  wire logic              [rsm_pkg::VALUE_WIDTH-1:0] b,
    output rsm_pkg::unit_res_t                                res
);
    import rsm_pkg::*;

    // Compare for the insertion scan
    assign res.gt = (a > b);

    // Floor of the mean: halves plus carry of the two dropped low bits
    assign res.mean = (a >> 1) + (b >> 1) + word_t'(a[0] & b[0]);

endmodule

`default_nettype wire

FILE: rtl/running_set_median.sv
// Top level: sorted-insertion sequencer and median readout for a running set.
//
// A set of signed Q15.16 values is fed one transaction at a time (start while
// busy is low); the final element carries last. Each value is placed in an
// ascending store by scanning down from the top, one stored element per
// cycle, through a single RAM read port and one shared compare unit. An
// accepted value shifts each held value greater than it up one entry and is
// then written into the gap, at the bottom (ST_PLACE) when all are greater.
// A value into an empty store is written on acceptance and one into a full
// store is dropped (overflow set); busy rises for these only with last. A
// last transaction keeps busy high through ST_MED_ADDR, ST_MED_A and, with
// an even count, ST_MED_B, to read the middle element(s); median_value,
// used_count and overflow appear for exactly one cycle with done high, in the
// first cycle that busy is low again. The receiver cannot stall: done is a
// strobe and must be captured in that cycle. The store then starts empty for
// the next set.
`default_nettype none

module running_set_median (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [rsm_pkg::VALUE_WIDTH-1:0] value,
    input  wire logic                                   last,
    output logic                                        done,
    output logic signed      [rsm_pkg::MEDIAN_W-1:0]    median_value,
    output logic             [rsm_pkg::USED_W-1:0]      used_count,
    output logic                                        overflow
);
    import rsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_MED_ADDR,
        ST_MED_A,
        ST_MED_B
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  drop_reg, drop_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    word_t                 opnd_reg, opnd_next;
    logic                  last_reg, last_next;
    logic                  done_reg, done_next;
    word_t                 median_reg, median_next;
    logic [USED_W-1:0]     used_reg, used_next;
    logic                  ovf_reg, ovf_next;

    logic                  accept;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    word_t                 ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    word_t                 ram_rdata;
    unit_res_t             unit_res;
    word_t                 value_biased;
    logic [ADDR_W-1:0]     half_addr;

    assign accept       = start && (state_reg == ST_IDLE);
    assign value_biased = word_t'(value) ^ VAL_BIAS;
    assign half_addr    = ADDR_W'(count_reg >> 1);

    rsm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (MAX_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared unit: stored word against the held operand
    rsm_unit u_unit (
        .a   (ram_rdata),
        .b   (opnd_reg),
        .res (unit_res)
    );

    // Sequencer next-state, store port and result logic
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        drop_next   = drop_reg;
        pos_next    = pos_reg;
        opnd_next   = opnd_reg;
        last_next   = last_reg;
        done_next   = 1'b0;
        median_next = median_reg;
        used_next   = used_reg;
        ovf_next    = ovf_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = opnd_reg;
        ram_raddr   = ADDR_W'(pos_reg - ADDR_W'(2));

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = ADDR_W'(count_reg - CNT_W'(1));
                if (accept)
                begin
                    opnd_next = value_biased;
                    last_next = last;
                    if (count_reg == CNT_W'(MAX_COUNT))
                    begin
                        // store full: drop the value
                        drop_next = 1'b1;
                        if (last)
                        begin
                            state_next = ST_MED_ADDR;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        // empty store: value goes straight to the bottom
                        ram_we     = 1'b1;
                        ram_waddr  = '0;
                        ram_wdata  = value_biased;
                        count_next = CNT_W'(1);
                        if (last)
                        begin
                            state_next = ST_MED_ADDR;
                        end
                    end
                    else
                    begin
                        pos_next   = ADDR_W'(count_reg);
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // entry pos-1 is on the read port
                ram_we = 1'b1;
                if (unit_res.gt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = ADDR_W'(pos_reg - ADDR_W'(1));
                    if (pos_reg == ADDR_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    ram_wdata  = opnd_reg;
                    count_next = CNT_W'(count_reg + CNT_W'(1));
                    state_next = last_reg ? ST_MED_ADDR : ST_IDLE;
                end
            end

            ST_PLACE:
            begin
                // every held value was greater: new value at the bottom
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = opnd_reg;
                count_next = CNT_W'(count_reg + CNT_W'(1));
                state_next = last_reg ? ST_MED_ADDR : ST_IDLE;
            end

            ST_MED_ADDR:
            begin
                // odd: middle element; even: lower middle first
                ram_raddr  = count_reg[0] ? half_addr : ADDR_W'(half_addr - ADDR_W'(1));
                state_next = ST_MED_A;
            end

            ST_MED_A:
            begin
                ram_raddr = half_addr;
                if (count_reg[0])
                begin
                    median_next = ram_rdata ^ VAL_BIAS;
                    used_next   = USED_W'(count_reg);
                    ovf_next    = drop_reg;
                    done_next   = 1'b1;
                    count_next  = '0;
                    drop_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    opnd_next  = ram_rdata;
                    state_next = ST_MED_B;
                end
            end

            ST_MED_B:
            begin
                median_next = unit_res.mean ^ VAL_BIAS;
                used_next   = USED_W'(count_reg);
                ovf_next    = drop_reg;
                done_next   = 1'b1;
                count_next  = '0;
                drop_next   = 1'b0;
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            drop_reg   <= 1'b0;
            last_reg   <= 1'b0;
            done_reg   <= 1'b0;
            pos_reg    <= '0;
            opnd_reg   <= '0;
            median_reg <= '0;
            used_reg   <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            drop_reg   <= drop_next;
            last_reg   <= last_next;
            done_reg   <= done_next;
            pos_reg    <= pos_next;
            opnd_reg   <= opnd_next;
            median_reg <= median_next;
            used_reg   <= used_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign median_value = MEDIAN_W'(median_reg);
    assign used_count   = used_reg;
    assign overflow     = ovf_reg;

    // A result is strobed only once the sequencer is back at idle with an empty store
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && count_reg == '0 && !drop_reg))
        else $error("result strobe without a cleared store");

    // The held count never exceeds capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_COUNT))
        else $error("held count beyond capacity");

    // The scan never runs below the bottom entry
    a_scan_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (pos_reg != '0))
        else $error("insertion scan at entry zero");

    // The store is written only during an insertion
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (accept || state_reg == ST_SCAN || state_reg == ST_PLACE))
        else $error("store write outside insertion");

    // A dropped value leaves the held count unchanged
    a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && count_reg == CNT_W'(MAX_COUNT)) |=> (count_reg == CNT_W'(MAX_COUNT)))
        else $error("held count changed on a dropped value");

endmodule

`default_nettype wire

FILE: dv/tb_running_set_median.sv
// Testbench for running_set_median: sorted-set median tracker with self-checking scoreboard.

// Expected outcome of one completed set
typedef struct {
    logic signed [rsm_pkg::MEDIAN_W-1:0] median;
    logic        [rsm_pkg::USED_W-1:0]   used;
    logic                                ovf;
} set_median_t;

// Tracks the current set in sorted order and queues the median due for each closed set
class set_median_tracker;
    logic signed [rsm_pkg::VALUE_WIDTH-1:0] sorted_vals[$];
    bit                                     dropped;
    set_median_t                            pending_medians[$];
    int unsigned                            mismatches;

    // Accepted input transaction: insert after equal values, close the set on last
    function void note_sample(logic signed [rsm_pkg::VALUE_WIDTH-1:0] v, logic lst);
        int                                   pos;
        int                                   n;
        logic signed [rsm_pkg::VALUE_WIDTH:0] pair_sum;
        set_median_t                          r;
        if (sorted_vals.size() < rsm_pkg::MAX_COUNT)
        begin
            pos = sorted_vals.size();
            while (pos > 0 && sorted_vals[pos-1] > v)
                pos--;
            sorted_vals.insert(pos, v);
        end
        else
            dropped = 1'b1;
        if (!lst)
            return;
        n = sorted_vals.size();
        if (n % 2 == 1)
            r.median = sorted_vals[n/2];
        else
        begin
            // one bit wider sum, arithmetic halving gives the floor
            pair_sum = {sorted_vals[n/2-1][rsm_pkg::VALUE_WIDTH-1], sorted_vals[n/2-1]}
                     + {sorted_vals[n/2][rsm_pkg::VALUE_WIDTH-1], sorted_vals[n/2]};
            r.median = pair_sum[rsm_pkg::VALUE_WIDTH:1];
        end
        r.used = n[rsm_pkg::USED_W-1:0];
        r.ovf  = dropped;
        pending_medians = {pending_medians, r};
        sorted_vals.delete();
        dropped = 1'b0;
    endfunction

    // Result strobe: compare against the oldest pending set
    function void check_median(logic signed [rsm_pkg::MEDIAN_W-1:0] med,
                               logic [rsm_pkg::USED_W-1:0] used, logic ovf);
        set_median_t want;
        if (pending_medians.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result median=%0d used=%0d ovf=%0b",
                         med, used, ovf);
            return;
        end
        want = pending_medians.pop_front();
        if (med !== want.median || used !== want.used || ovf !== want.ovf)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: median exp=%0d act=%0d used exp=%0d act=%0d ovf exp=%0b act=%0b",
                         want.median, med, want.used, used, want.ovf, ovf);
        end
    endfunction
endclass

module tb_running_set_median;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TARGET_ITEMS = 1650;
    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam logic signed [rsm_pkg::VALUE_WIDTH-1:0] MAXV =
        {1'b0, {(rsm_pkg::VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [rsm_pkg::VALUE_WIDTH-1:0] MINV =
        {1'b1, {(rsm_pkg::VALUE_WIDTH-1){1'b0}}};

    logic                                   clk;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic signed [rsm_pkg::VALUE_WIDTH-1:0] value;
    logic                                   last;
    logic                                   done;
    logic signed [rsm_pkg::MEDIAN_W-1:0]    median_value;
    logic        [rsm_pkg::USED_W-1:0]      used_count;
    logic                                   overflow;

    set_median_tracker tracker = new;

    int          items_sent;
    int          burst_left;
    int unsigned cycle_count;
    logic signed [rsm_pkg::VALUE_WIDTH-1:0] prev_val;

    running_set_median uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last         (last),
        .done         (done),
        .median_value (median_value),
        .used_count   (used_count),
        .overflow     (overflow)
    );

    // 20 ns clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result monitor, sampled at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_median(median_value, used_count, overflow);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Random element: full range, small cluster, extremes, repeats, near extremes
    function automatic logic signed [rsm_pkg::VALUE_WIDTH-1:0] rand_value();
        logic signed [rsm_pkg::VALUE_WIDTH-1:0] v;
        case ($urandom_range(0, 9))
            5, 6:    v = int'($urandom_range(0, 16)) - 8;
            7:
            begin
                case ($urandom_range(0, 3))
                    0:       v = MAXV;
                    1:       v = MINV;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            8:       v = prev_val;
            9:       v = $urandom_range(0, 1) ? MAXV - $urandom_range(0, 3)
                                              : MINV + $urandom_range(0, 3);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // One input transaction: present at the falling edge, hold until accepted
    task automatic send_value(logic signed [rsm_pkg::VALUE_WIDTH-1:0] v, logic lst);
        @(negedge clk);
        start <= 1'b1;
        value <= v;
        last  <= lst;
        do
            @(posedge clk);
        while (busy);
        tracker.note_sample(v, lst);
        prev_val = v;
        items_sent++;
    endtask

    // Sender pacing: bursts of back-to-back transactions separated by idle gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 8);
        @(negedge clk);
        start <= 1'b0;
        value <= $urandom;
        last  <= $urandom_range(0, 1);
        repeat (gap - 1) @(negedge clk);
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 12);
    endtask

    // One set; order 0 is random content, order 1 is strictly descending
    task automatic send_set(int size, int order);
        logic signed [rsm_pkg::VALUE_WIDTH-1:0] v;
        for (int i = 0; i < size; i++)
        begin
            v = (order == 1) ? MAXV - i : rand_value();
            send_value(v, i == size - 1);
            pace();
        end
    endtask

    initial
    begin
        int set_idx;
        int size;
        rst_n      = 1'b0;
        start      = 1'b0;
        value      = '0;
        last       = 1'b0;
        items_sent = 0;
        burst_left = 0;
        prev_val   = '0;
        cycle_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: single elements, sum overflow, floor on negatives, ties, order
        send_value(MAXV, 1'b1);
        send_value(MINV, 1'b1);
        send_value(MAXV, 1'b0);
        send_value(MAXV, 1'b1);
        send_value(MINV, 1'b0);
        send_value(MINV, 1'b1);
        send_value(MINV, 1'b0);
        send_value(MAXV, 1'b1);
        send_value('0, 1'b0);
        send_value('1, 1'b1);
        send_value(-3, 1'b0);
        send_value('0, 1'b1);
        send_value(7, 1'b0);
        send_value(7, 1'b0);
        send_value(7, 1'b1);
        send_value(4, 1'b0);
        send_value(3, 1'b0);
        send_value(2, 1'b0);
        send_value(1, 1'b1);
        send_value(1, 1'b0);
        send_value(-1, 1'b0);
        send_value(5, 1'b1);
        send_value(32'h5555_5555, 1'b0);
        send_value(32'hAAAA_AAAA, 1'b1);

        // Random sets; a few fill the store exactly, overfill it, or drop the last element
        set_idx = 0;
        while (items_sent < TARGET_ITEMS)
        begin
            case (set_idx)
                3:       send_set(rsm_pkg::MAX_COUNT, 0);
                20:      send_set(rsm_pkg::MAX_COUNT + 1, 1);
                40:      send_set(rsm_pkg::MAX_COUNT + $urandom_range(2, 40), 0);
                60:      send_set(rsm_pkg::MAX_COUNT - 1, 0);
                default:
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: size = $urandom_range(1, 3);
                        9:          size = $urandom_range(25, 64);
                        default:    size = $urandom_range(4, 24);
                    endcase
                    send_set(size, 0);
                end
            endcase
            set_idx++;
        end

        // Drain: stop driving, wait out the last median
        @(negedge clk);
        start <= 1'b0;
        while (tracker.pending_medians.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
